[hw/rtl/kmpff_pkg.sv]
// Types and codes shared by the KMP first-match finder modules.
package kmpff_pkg;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_TEXT   = 2'd2;
  localparam logic [1:0] FUNC_END    = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] position;
  } out_item_t;

  typedef struct packed {
    logic       clear;
    logic       append;
    logic       text;
    logic       fin;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

[hw/rtl/kmp_first_match_finder_top.sv]
// Top level of the KMP first-match finder: front queue, back sequencer and checks.
// Clear and end items, text items that need no pattern compare, and appends to an
// empty or full pattern finish in S_IDLE of the back end; a text item that walks
// the pattern goes on to S_PAT, an append to a nonempty pattern to S_FAIL, then
// S_PAT, and each failure-chain step adds S_FAIL and S_PAT, as the reads of the
// pattern and failure memories are registered (one read of each per cycle). A
// two-slot queue in front keeps input accepted while the back end walks, and the
// result register is free to be taken while the next item is read from the queue;
// a result that is not taken holds the back end. Up to MAX_PATTERN pattern bytes
// are held; further appends are dropped and the search then reports not-found.
module kmp_first_match_finder_top #(
  parameter int MAX_PATTERN = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  kmpff_pkg::in_item_t   cmd,
  output logic                  res_valid,
  input  logic                  res_stall,
  output kmpff_pkg::out_item_t  res
);

  kmpff_pkg::queue_head_t head;
  logic                   pop;

  kmpff_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .head      (head),
    .pop       (pop)
  );

  kmpff_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  a_notfound_pos_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.found |-> res.position == 32'd0)
    else $error("Not-found result carries a nonzero position.");

  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> head.valid)
    else $error("Input stalled while the queue is empty.");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("Queue popped while empty.");

endmodule

[hw/rtl/kmpff_front.sv]
// Front end: accepts items, decodes the function code and queues them in two slots.
module kmpff_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  output logic                    cmd_stall,
  input  kmpff_pkg::in_item_t     cmd,
  output kmpff_pkg::queue_head_t  head,
  input  logic                    pop
);

  kmpff_pkg::cmd_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  kmpff_pkg::cmd_t decoded;
  logic            push;

  always_comb begin
    decoded = '0;
    decoded.data = cmd.byte_value;
    case (cmd.func)
      kmpff_pkg::FUNC_CLEAR:  decoded.clear  = 1'b1;
      kmpff_pkg::FUNC_APPEND: decoded.append = 1'b1;
      kmpff_pkg::FUNC_TEXT:   decoded.text   = 1'b1;
      kmpff_pkg::FUNC_END:    decoded.fin    = 1'b1;
      default:                decoded.fin    = 1'b1;
    endcase
  end

  assign cmd_stall  = (count == 2'd2);
  assign push       = cmd_valid && !cmd_stall;
  assign head.valid = (count != 2'd0);
  assign head.cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[hw/rtl/kmpff_back.sv]
// Back end: pattern and failure memories, failure-chain walker and result register.
module kmpff_back #(
  parameter int MAX_PATTERN = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  kmpff_pkg::queue_head_t  head,
  output logic                    pop,
  output logic                    res_valid,
  input  logic                    res_stall,
  output kmpff_pkg::out_item_t    res
);

  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_PATTERN);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FAIL = 2'd1;
  localparam logic [1:0] S_PAT  = 2'd2;

  logic [7:0]    pat_mem  [MAX_PATTERN];
  logic [LW-1:0] fail_mem [MAX_PATTERN];
  logic [7:0]    pat_q;
  logic [LW-1:0] fail_q;

  logic          pat_we;
  logic [IW-1:0] pat_waddr;
  logic [IW-1:0] pat_raddr;
  logic          fail_we;
  logic [IW-1:0] fail_waddr;
  logic [LW-1:0] fail_wdata;
  logic [IW-1:0] fail_raddr;

  logic [1:0]    state;
  logic          walk_text;
  logic [7:0]    ch;
  logic [LW-1:0] k;
  logic [LW-1:0] len;
  logic          ovf;
  logic [LW-1:0] matched;
  logic [31:0]   pos;
  logic [31:0]   here;
  logic          done;

  logic          out_free;
  logic [LW-1:0] q_start;
  logic [LW-1:0] k_inc;
  logic          mismatch_step;
  logic [LW-1:0] len_dec;
  logic [LW-1:0] k_dec;
  logic          res_set;

  assign out_free      = !res_valid || !res_stall;
  assign pop           = (state == S_IDLE) && head.valid && out_free;
  assign q_start       = (matched >= len) ? '0 : matched;
  assign k_inc         = k + LW'(pat_q == ch);
  assign mismatch_step = (k != '0) && (pat_q != ch);
  assign len_dec       = len - LW'(1);
  assign k_dec         = k - LW'(1);
  assign res_set       = (pop && !done && ((head.cmd.text && !ovf && (len == '0)) ||
                                           head.cmd.fin)) ||
                         ((state == S_PAT) && walk_text && !mismatch_step && (k_inc == len));

  always_comb begin
    pat_we     = 1'b0;
    pat_waddr  = len[IW-1:0];
    pat_raddr  = '0;
    fail_we    = 1'b0;
    fail_waddr = len[IW-1:0];
    fail_wdata = '0;
    fail_raddr = len_dec[IW-1:0];
    case (state)
      S_IDLE: begin
        if (pop && head.cmd.append && (len != LEN_MAX)) begin
          pat_we = 1'b1;
          if (len == '0) begin
            fail_we = 1'b1;
          end
        end
        pat_raddr = q_start[IW-1:0];
      end
      S_FAIL: begin
        pat_raddr = fail_q[IW-1:0];
      end
      S_PAT: begin
        if (mismatch_step) begin
          fail_raddr = k_dec[IW-1:0];
        end else if (!walk_text) begin
          fail_we    = 1'b1;
          fail_wdata = k_inc;
        end
      end
      default: begin
        pat_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[pat_waddr] <= head.cmd.data;
    end
    pat_q <= pat_mem[pat_raddr];
  end

  always_ff @(posedge clk) begin
    if (fail_we) begin
      fail_mem[fail_waddr] <= fail_wdata;
    end
    fail_q <= fail_mem[fail_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      walk_text <= 1'b0;
      len       <= '0;
      ovf       <= 1'b0;
      matched   <= '0;
      pos       <= '0;
      done      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_set) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            if (head.cmd.clear) begin
              len     <= '0;
              ovf     <= 1'b0;
              matched <= '0;
              pos     <= '0;
              done    <= 1'b0;
            end else if (head.cmd.append) begin
              matched <= '0;
              pos     <= '0;
              done    <= 1'b0;
              if (len == LEN_MAX) begin
                ovf <= 1'b1;
              end else if (len == '0) begin
                len <= LW'(1);
              end else begin
                ch        <= head.cmd.data;
                walk_text <= 1'b0;
                state     <= S_FAIL;
              end
            end else if (head.cmd.text) begin
              if (!done) begin
                here <= pos;
                if (pos != '1) begin
                  pos <= pos + 32'd1;
                end
                if (!ovf) begin
                  if (len == '0) begin
                    done         <= 1'b1;
                    res.found    <= 1'b1;
                    res.position <= '0;
                  end else begin
                    k         <= q_start;
                    ch        <= head.cmd.data;
                    walk_text <= 1'b1;
                    state     <= S_PAT;
                  end
                end
              end
            end else if (head.cmd.fin) begin
              if (!done) begin
                res.found    <= (len == '0) && !ovf;
                res.position <= '0;
              end
              matched <= '0;
              pos     <= '0;
              done    <= 1'b0;
            end
          end
        end
        S_FAIL: begin
          k     <= fail_q;
          state <= S_PAT;
        end
        S_PAT: begin
          if (mismatch_step) begin
            state <= S_FAIL;
          end else begin
            state <= S_IDLE;
            if (!walk_text) begin
              len <= len + LW'(1);
            end else if (k_inc == len) begin
              done         <= 1'b1;
              matched      <= '0;
              res.found    <= 1'b1;
              res.position <= here - 32'(len) + 32'd1;
            end else begin
              matched <= k_inc;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[dv/tb_kmp_first_match_finder_top.sv]
// Testbench for the KMP first-match finder: directed table, random streams, scoreboard.
`timescale 1ns / 100ps

module tb_kmp_first_match_finder_top;

  localparam int MAX_PAT = 64;

  logic                 clk;
  logic                 rst;
  logic                 cmd_valid;
  logic                 cmd_stall;
  kmpff_pkg::in_item_t  cmd;
  logic                 res_valid;
  logic                 res_stall;
  kmpff_pkg::out_item_t res;

  logic [7:0]  pat_mem [MAX_PAT];
  logic [6:0]  fail_mem [MAX_PAT];
  int unsigned pat_len;
  logic        pat_over;
  int unsigned match_q;
  logic [31:0] text_pos;
  logic        hit_done;

  kmpff_pkg::out_item_t pending_results [$];
  kmpff_pkg::in_item_t  item_queue [$];
  logic                 fixed_want [$];
  kmpff_pkg::out_item_t fixed_result [$];
  logic                 pred_made;
  kmpff_pkg::out_item_t pred_last;
  int                   error_count;
  int                   result_count;
  int                   item_count;

  kmp_first_match_finder_top #(.MAX_PATTERN(MAX_PAT)) i_dut (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic void finder_reset();
    pat_len = 0;
    pat_over = 1'b0;
    match_q = 0;
    text_pos = '0;
    hit_done = 1'b0;
  endfunction

  function automatic void push_result(input kmpff_pkg::out_item_t r);
    pending_results.push_back(r);
    pred_made = 1'b1;
    pred_last = r;
  endfunction

  function automatic void predict_search(input kmpff_pkg::in_item_t it);
    int unsigned i;
    int unsigned k;
    int unsigned q;
    logic [31:0] here;
    kmpff_pkg::out_item_t r;
    pred_made = 1'b0;
    case (it.func)
      kmpff_pkg::FUNC_CLEAR: begin
        pat_len = 0;
        pat_over = 1'b0;
      end
      kmpff_pkg::FUNC_APPEND: begin
        i = pat_len;
        if (i >= MAX_PAT) begin
          pat_over = 1'b1;
        end else begin
          pat_mem[i] = it.byte_value;
          k = 0;
          if (i > 0) begin
            k = 32'(fail_mem[i-1]);
            while (k > 0 && pat_mem[k] != it.byte_value) k = 32'(fail_mem[k-1]);
            if (pat_mem[k] == it.byte_value && k < i) k++;
          end
          fail_mem[i] = k[6:0];
          pat_len = i + 1;
        end
      end
      kmpff_pkg::FUNC_END: begin
        if (!hit_done) begin
          r.found = (pat_len == 0) && !pat_over;
          r.position = '0;
          push_result(r);
        end
      end
      default: begin
        if (!hit_done) begin
          here = text_pos;
          if (text_pos != 32'hFFFF_FFFF) text_pos++;
          if (!pat_over) begin
            if (pat_len == 0) begin
              hit_done = 1'b1;
              r.found = 1'b1;
              r.position = '0;
              push_result(r);
            end else begin
              q = (match_q >= pat_len) ? 0 : match_q;
              while (q > 0 && pat_mem[q] != it.byte_value) q = 32'(fail_mem[q-1]);
              if (pat_mem[q] == it.byte_value) q++;
              if (q == pat_len) begin
                hit_done = 1'b1;
                match_q = 0;
                r.found = 1'b1;
                r.position = here - (pat_len - 1);
                push_result(r);
              end else begin
                match_q = q;
              end
            end
          end
        end
        return;
      end
    endcase
    match_q = 0;
    text_pos = '0;
    hit_done = 1'b0;
  endfunction

  function automatic kmpff_pkg::in_item_t make_item(input logic [1:0] f, input logic [7:0] v);
    kmpff_pkg::in_item_t it;
    it.func = f;
    it.byte_value = v;
    return it;
  endfunction

  task automatic add_item(input logic [1:0] f, input logic [7:0] v, input logic has_w = 1'b0,
                          input logic w_found = 1'b0, input logic [31:0] w_pos = '0);
    kmpff_pkg::out_item_t r;
    item_queue.push_back(make_item(f, v));
    fixed_want.push_back(has_w);
    r.found = w_found;
    r.position = w_pos;
    fixed_result.push_back(r);
  endtask

  // Random stream: a short pattern, then text seeded with copies of it.
  task automatic add_random_search();
    int unsigned len;
    int unsigned n;
    logic [7:0] alpha;
    logic [7:0] p [$];
    p = {};
    alpha = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'h03;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 66) : $urandom_range(0, 5);
    add_item(kmpff_pkg::FUNC_CLEAR, 8'($urandom));
    for (int i = 0; i < len; i++) begin
      p.push_back(8'($urandom) & alpha);
      add_item(kmpff_pkg::FUNC_APPEND, p[i]);
    end
    n = (len > 8) ? $urandom_range(1, 3) : $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      if (p.size() > 0 && $urandom_range(0, 4) == 0) begin
        foreach (p[j]) begin
          add_item(kmpff_pkg::FUNC_TEXT,
                   p[j] ^ (($urandom_range(0, 7) == 0) ? 8'h01 : 8'h00));
        end
      end else begin
        add_item($urandom_range(0, 15) == 0 ? kmpff_pkg::FUNC_APPEND : kmpff_pkg::FUNC_TEXT,
                 8'($urandom) & alpha);
      end
    end
    add_item(kmpff_pkg::FUNC_END, 8'($urandom));
    if ($urandom_range(0, 2) == 0) begin
      for (int i = 0; i < 4; i++) add_item(kmpff_pkg::FUNC_TEXT, 8'($urandom) & alpha);
      add_item(kmpff_pkg::FUNC_END, 8'($urandom));
    end
  endtask

  initial begin
    logic [1:0] dir_func [25];
    logic [7:0] dir_val  [25];
    logic       dir_has  [25];
    logic       dir_fnd  [25];
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    error_count = 0;
    finder_reset();
    // Directed table: empty pattern hit, extremes, failure chain, not-found.
    dir_func = '{kmpff_pkg::FUNC_END, kmpff_pkg::FUNC_TEXT, kmpff_pkg::FUNC_END,
                 kmpff_pkg::FUNC_TEXT, kmpff_pkg::FUNC_END,
                 kmpff_pkg::FUNC_APPEND, kmpff_pkg::FUNC_APPEND, kmpff_pkg::FUNC_APPEND,
                 kmpff_pkg::FUNC_TEXT, kmpff_pkg::FUNC_TEXT,
                 kmpff_pkg::FUNC_TEXT, kmpff_pkg::FUNC_TEXT, kmpff_pkg::FUNC_TEXT,
                 kmpff_pkg::FUNC_END,
                 kmpff_pkg::FUNC_CLEAR, kmpff_pkg::FUNC_APPEND, kmpff_pkg::FUNC_TEXT,
                 kmpff_pkg::FUNC_END,
                 kmpff_pkg::FUNC_CLEAR, kmpff_pkg::FUNC_APPEND, kmpff_pkg::FUNC_APPEND,
                 kmpff_pkg::FUNC_TEXT, kmpff_pkg::FUNC_TEXT,
                 kmpff_pkg::FUNC_TEXT, kmpff_pkg::FUNC_END};
    dir_val  = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00,
                 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'hAA, 8'h55, 8'h55, 8'h00,
                 8'hFF, 8'hFF, 8'h00, 8'hFF,
                 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00};
    dir_has  = '{1, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0};
    dir_fnd  = '{1, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    for (int i = 0; i < 25; i++) add_item(dir_func[i], dir_val[i], dir_has[i], dir_fnd[i], '0);
    // Overflow of the pattern store.
    add_item(kmpff_pkg::FUNC_CLEAR, 8'h00);
    for (int i = 0; i <= MAX_PAT; i++) add_item(kmpff_pkg::FUNC_APPEND, 8'h11);
    for (int i = 0; i < MAX_PAT; i++) add_item(kmpff_pkg::FUNC_TEXT, 8'h11);
    add_item(kmpff_pkg::FUNC_END, 8'h00, 1'b1, 1'b0, '0);
    while (item_queue.size() < 630) add_random_search();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    int gap;
    int burst;
    logic want_fixed;
    kmpff_pkg::in_item_t it;
    kmpff_pkg::out_item_t fix_res;
    item_count = 0;
    @(negedge rst);
    @(posedge clk);
    while (item_queue.size() > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && item_queue.size() > 0) begin
        it = item_queue.pop_front();
        want_fixed = fixed_want.pop_front();
        fix_res = fixed_result.pop_front();
        cmd <= it;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        predict_search(it);
        if (want_fixed) begin
          if (!pred_made) begin
            report_mismatch("typed result missing from the prediction");
          end else if (pred_last !== fix_res) begin
            report_mismatch($sformatf("prediction %0b/%0d, typed %0b/%0d",
                                      pred_last.found, pred_last.position,
                                      fix_res.found, fix_res.position));
          end
        end
        item_count++;
        burst--;
      end
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    cmd_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Ran %0d items through directed and random search streams, %0d results.",
             item_count, result_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    res_stall = 1'b0;
    @(negedge rst);
    repeat (400) @(posedge clk);
    res_stall <= 1'b1;
    repeat (600) @(posedge clk);
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 1) == 0 && $time > 20000) res_stall <= 1'b0;
      else res_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    kmpff_pkg::out_item_t want;
    if (rst) begin
      result_count <= 0;
    end else if (res_valid && !res_stall) begin
      result_count <= result_count + 1;
      if (pending_results.size() == 0) begin
        report_mismatch("result with none expected");
      end else begin
        want = pending_results.pop_front();
        if (res.found !== want.found)
          report_mismatch($sformatf("found %0b, want %0b", res.found, want.found));
        if (res.position !== want.position)
          report_mismatch($sformatf("position %0d, want %0d", res.position, want.position));
      end
    end
  end

endmodule

[files.f]
hw/rtl/kmpff_pkg.sv
hw/rtl/kmpff_front.sv
hw/rtl/kmpff_back.sv
hw/rtl/kmp_first_match_finder_top.sv
dv/tb_kmp_first_match_finder_top.sv
